/* design/gdr_pkg.sv */
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared types, constants and saturation helper for the gated delta-rule
// state update block.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 64;               // product register width
  localparam int RND_W     = PROD_W - FRAC_BITS; // rounded product width
  localparam int ACC_W     = 56;               // dot accumulator, up to 256 terms
  localparam logic [16:0] GATE_ONE = 17'h10000;
  localparam logic [7:0]  KLEN_RESET = 8'd128;

  typedef struct packed {
    logic              op;
    logic [1:0]        head;
    logic [6:0]        position;
    logic signed [31:0] query_value;
    logic signed [31:0] key_value;
    logic signed [31:0] value_element;
    logic [16:0]       decay;
    logic [16:0]       rate;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        out_head;
    logic [6:0]        out_row;
    logic signed [31:0] out_value;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_MUL,
    S_A_SAT,
    S_A_MULK,
    S_A_ACC,
    S_DLT,
    S_DLT_MUL,
    S_DLT_SAT,
    S_B_RD,
    S_B_MUL,
    S_B_SUM,
    S_B_MULQ,
    S_B_ACC,
    S_OUT
  } seq_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* design/gdr_mul.sv */
// ----------------------------------------------------------------------------
// gdr_mul
// Shared signed multiplier with registered product and Q16 round-to-nearest
// (ties up) of the registered product.
// ----------------------------------------------------------------------------
module gdr_mul (
  input  logic                                clk,
  input  logic signed [32:0]                  mul_a,
  input  logic signed [32:0]                  mul_b,
  output logic signed [gdr_pkg::RND_W-1:0]    mul_rnd
);
  import gdr_pkg::*;

  logic signed [65:0]       full;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] half_sum;

  // operand magnitudes keep the product within 2^62, so 64 bits are exact
  assign full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= $signed(full[PROD_W-1:0]);
  end

  // add half, then floor shift
  assign half_sum = prod_r + $signed(PROD_W'(1) << (FRAC_BITS - 1));
  assign mul_rnd  = $signed(half_sum[PROD_W-1:FRAC_BITS]);

endmodule

/* design/gated_delta_rule_state_update.sv */
// ----------------------------------------------------------------------------
// gated_delta_rule_state_update
// Gated delta-rule recurrent state update in Q16.16 fixed point.
//
// Input word: taken at a clock edge with start high and busy low.
//   op 0 (load): writes one query and one key element for a head/column;
//   busy stays low and there is no result word.
//   op 1 (update): decays one state row by alpha, dots it with k, forms
//   delta = (v - dot) * beta, adds delta*k to the row and dots the new row
//   with q, over cols = min(key_length, KEY_DIM) columns, with busy high;
//   one shared multiplier, five steps per column per pass, two passes per
//   row, plus three for delta and one for the output. The result word shows
//   on out_word with out_valid for one cycle, the first cycle with busy low
//   again, when a new input word can already be taken.
//   Items with head or position out of range are dropped without a result.
// Config: cfg_we writes key_length from cfg_wdata; reset value 128.
// Reset: after rst_n the state memory is swept to zero, one entry a cycle,
//   all HEADS*ROW_COUNT*KEY_DIM entries (65536 by default), with busy high.
//   Query/key stores are not cleared; load them before use.
// The receiver cannot stall: each result word must be taken when shown.
// ----------------------------------------------------------------------------
module gated_delta_rule_state_update #(
  parameter int HEADS     = 4,
  parameter int KEY_DIM   = 128,
  parameter int ROW_COUNT = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gdr_pkg::in_word_t   in_word,
  output logic                out_valid,
  output gdr_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import gdr_pkg::*;

  localparam int ST_DEPTH = HEADS * ROW_COUNT * KEY_DIM;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int QK_DEPTH = HEADS * KEY_DIM;
  localparam int QK_AW    = $clog2(QK_DEPTH);
  localparam int CW       = $clog2(KEY_DIM + 1);

  // storage
  logic signed [31:0] state_mem [ST_DEPTH];
  logic signed [31:0] q_mem [QK_DEPTH];
  logic signed [31:0] k_mem [QK_DEPTH];

  seq_state_t          state_r, state_nxt;
  logic [ST_AW-1:0]    clr_r, clr_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0]  d_r, d_nxt;
  logic signed [31:0]  dlt_r, dlt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r;
  logic [7:0]          klen_r;

  logic [1:0]          head_r;
  logic [6:0]          row_r;
  logic signed [31:0]  v_r;
  logic [16:0]         alpha_r;
  logic [16:0]         beta_r;
  logic [ST_AW-1:0]    st_base_r;
  logic [QK_AW-1:0]    qk_base_r;

  logic signed [31:0]  st_rd_r;
  logic signed [31:0]  q_rd_r;
  logic signed [31:0]  k_rd_r;

  logic                accept;
  logic                head_ok;
  logic                ld_go;
  logic                upd_go;
  logic [CW-1:0]       cols;
  logic [ST_AW-1:0]    st_addr;
  logic [QK_AW-1:0]    qk_addr;
  logic [QK_AW-1:0]    qk_waddr;
  logic                st_we;
  logic [ST_AW-1:0]    st_waddr;
  logic signed [31:0]  st_wdata;
  logic                rd_en;

  logic signed [32:0]        mul_a;
  logic signed [32:0]        mul_b;
  logic signed [RND_W-1:0]   mul_rnd;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign head_ok   = (32'(in_word.head) < HEADS);
  assign ld_go     = accept && !in_word.op && head_ok && (32'(in_word.position) < KEY_DIM);
  assign upd_go    = accept && in_word.op && head_ok && (32'(in_word.position) < ROW_COUNT);
  assign cols      = (32'(klen_r) > KEY_DIM) ? CW'(KEY_DIM) : CW'(klen_r);
  assign st_addr   = st_base_r + ST_AW'(col_r);
  assign qk_addr   = qk_base_r + QK_AW'(col_r);
  assign qk_waddr  = QK_AW'(32'(in_word.head) * KEY_DIM + 32'(in_word.position));
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  gdr_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_rnd (mul_rnd)
  );

  // sequencer: clear sweep; per column, read / multiply / saturate or sum / multiply / accumulate; delta and output
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    col_nxt       = col_r;
    acc_nxt       = acc_r;
    d_nxt         = d_r;
    dlt_nxt       = dlt_r;
    out_valid_nxt = 1'b0;
    st_we         = 1'b0;
    st_waddr      = st_addr;
    st_wdata      = '0;
    rd_en         = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        clr_nxt  = clr_r + ST_AW'(1);
        if (clr_r == ST_AW'(ST_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (upd_go) begin
          col_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = (cols == '0) ? S_DLT : S_A_RD;
        end
      end
      S_A_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_A_MUL;
      end
      S_A_MUL: begin
        mul_a     = 33'(st_rd_r);
        mul_b     = $signed({16'b0, alpha_r});
        state_nxt = S_A_SAT;
      end
      S_A_SAT: begin
        d_nxt     = sat32(64'(mul_rnd));
        st_we     = 1'b1;
        st_wdata  = d_nxt;
        state_nxt = S_A_MULK;
      end
      S_A_MULK: begin
        mul_a     = 33'(d_r);
        mul_b     = 33'(k_rd_r);
        state_nxt = S_A_ACC;
      end
      S_A_ACC: begin
        acc_nxt   = acc_r + ACC_W'(mul_rnd);
        col_nxt   = col_r + CW'(1);
        state_nxt = (col_nxt == cols) ? S_DLT : S_A_RD;
      end
      S_DLT: begin
        dlt_nxt   = sat32(64'(v_r) - 64'(sat32(64'(acc_r))));
        acc_nxt   = '0;
        state_nxt = S_DLT_MUL;
      end
      S_DLT_MUL: begin
        mul_a     = 33'(dlt_r);
        mul_b     = $signed({16'b0, beta_r});
        state_nxt = S_DLT_SAT;
      end
      S_DLT_SAT: begin
        dlt_nxt   = sat32(64'(mul_rnd));
        col_nxt   = '0;
        state_nxt = (cols == '0) ? S_OUT : S_B_RD;
      end
      S_B_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_B_MUL;
      end
      S_B_MUL: begin
        mul_a     = 33'(dlt_r);
        mul_b     = 33'(k_rd_r);
        state_nxt = S_B_SUM;
      end
      S_B_SUM: begin
        d_nxt     = sat32(64'(st_rd_r) + 64'(mul_rnd));
        st_we     = 1'b1;
        st_wdata  = d_nxt;
        state_nxt = S_B_MULQ;
      end
      S_B_MULQ: begin
        mul_a     = 33'(d_r);
        mul_b     = 33'(q_rd_r);
        state_nxt = S_B_ACC;
      end
      S_B_ACC: begin
        acc_nxt   = acc_r + ACC_W'(mul_rnd);
        col_nxt   = col_r + CW'(1);
        state_nxt = (col_nxt == cols) ? S_OUT : S_B_RD;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      klen_r      <= KLEN_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        klen_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    acc_r <= acc_nxt;
    d_r   <= d_nxt;
    dlt_r <= dlt_nxt;
    if (upd_go) begin
      head_r    <= in_word.head;
      row_r     <= in_word.position;
      v_r       <= in_word.value_element;
      alpha_r   <= (in_word.decay > GATE_ONE) ? GATE_ONE : in_word.decay;
      beta_r    <= (in_word.rate > GATE_ONE) ? GATE_ONE : in_word.rate;
      st_base_r <= ST_AW'((32'(in_word.head) * ROW_COUNT + 32'(in_word.position)) * KEY_DIM);
      qk_base_r <= QK_AW'(32'(in_word.head) * KEY_DIM);
    end
    if (state_r == S_OUT) begin
      out_word_r.out_head  <= head_r;
      out_word_r.out_row   <= row_r;
      out_word_r.out_value <= sat32(64'(acc_r));
    end
  end

  // state memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[st_waddr] <= st_wdata;
    end
    if (rd_en) begin
      st_rd_r <= state_mem[st_addr];
    end
  end

  // query/key stores
  always_ff @(posedge clk) begin
    if (ld_go) begin
      q_mem[qk_waddr] <= in_word.query_value;
      k_mem[qk_waddr] <= in_word.key_value;
    end
    if (rd_en) begin
      q_rd_r <= q_mem[qk_addr];
      k_rd_r <= k_mem[qk_addr];
    end
  end

endmodule
